FILE: rtl/tss_pkg.sv
// tss_pkg: codes and small types shared by the time sync session sequencer.
// Event codes, phase codes and result kinds. No dependencies.
package tss_pkg;

    typedef logic [2:0] func_t;
    typedef logic [1:0] phase_t;
    typedef logic [2:0] kind_t;

    localparam func_t FN_START  = 3'd0;
    localparam func_t FN_REQUEST = 3'd1;
    localparam func_t FN_REPORT = 3'd2;
    localparam func_t FN_CANCEL = 3'd3;
    localparam func_t FN_RESET  = 3'd4;

    localparam phase_t PH_IDLE     = 2'd0;
    localparam phase_t PH_SYNC     = 2'd1;
    localparam phase_t PH_VERIFY   = 2'd2;
    localparam phase_t PH_COMPLETE = 2'd3;

    localparam kind_t K_NONE        = 3'd0;
    localparam kind_t K_STARTED     = 3'd1;
    localparam kind_t K_REPLY       = 3'd2;
    localparam kind_t K_ACCEPTED    = 3'd3;
    localparam kind_t K_CANCELLED   = 3'd4;
    localparam kind_t K_NOT_STARTED = 3'd5;
    localparam kind_t K_MISMATCH    = 3'd6;

    localparam logic CFG_SYNC_TARGET   = 1'b0;
    localparam logic CFG_VERIFY_TARGET = 1'b1;

    localparam logic [7:0] SYNC_TARGET_RST   = 8'd8;
    localparam logic [7:0] VERIFY_TARGET_RST = 8'd4;

    // state and result summary handed from the sequencer to the output stage
    typedef struct packed {
        kind_t  kind;
        phase_t phase;
        logic   status;   // status fields carried (else zero)
        logic   echo;     // reply echo fields carried
    } tss_res_ctl_t;

endpackage

FILE: rtl/tss_sequencer.sv
// tss_sequencer: session state, sample targets and the per-item decision logic.
// Depends on tss_pkg. State advances when step is high; results are combinational.
module tss_sequencer
    import tss_pkg::*;
#(
    parameter int SESSION_BITS = 16,
    parameter int COUNT_BITS   = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_index,
    input  logic [7:0]                     cfg_wdata,
    input  logic                           step,
    input  func_t                          func,
    input  logic [SESSION_BITS-1:0]        session_id,
    input  phase_t                         req_phase,
    input  logic [7:0]                     sample_index,
    input  logic [7:0]                     report_sync_count,
    input  logic [7:0]                     report_verify_count,
    input  logic signed [63:0]             offset_ns,
    input  logic signed [63:0]             rtt_ns,
    input  logic [1:0]                     offset_source,
    output tss_res_ctl_t                   res_ctl,
    output logic signed [SESSION_BITS:0]   session_out,
    output logic [COUNT_BITS-1:0]          sync_count_out,
    output logic [COUNT_BITS-1:0]          verify_count_out,
    output logic signed [63:0]             adopted_offset_out,
    output logic signed [63:0]             adopted_rtt_out,
    output logic [1:0]                     adopted_source_out
);

    // compare width: holds both a count and an 8-bit target or index
    localparam int CW = ((COUNT_BITS > 8) ? COUNT_BITS : 8) + 1;

    logic [7:0]                   sync_tgt_reg, verify_tgt_reg;
    logic                         active_reg, active_next;
    phase_t                       phase_reg, phase_next;
    logic signed [SESSION_BITS:0] sess_reg, sess_next;
    logic [COUNT_BITS-1:0]        sync_cnt_reg, sync_cnt_next;
    logic [COUNT_BITS-1:0]        ver_cnt_reg, ver_cnt_next;
    logic signed [63:0]           offset_reg, offset_next;
    logic signed [63:0]           rtt_reg, rtt_next;
    logic [1:0]                   source_reg, source_next;

    logic [CW-1:0] sync_tgt_x, ver_tgt_x, sync_cnt_x, ver_cnt_x;
    logic [CW-1:0] cur_x, tgt_x, idx_x, rs_x, rv_x;
    logic          sess_match, retry, req_ok, entering, continuing, rpt_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_tgt_reg   <= SYNC_TARGET_RST;
            verify_tgt_reg <= VERIFY_TARGET_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_SYNC_TARGET) begin
                sync_tgt_reg <= cfg_wdata;
            end else begin
                verify_tgt_reg <= cfg_wdata;
            end
        end
    end

    assign sync_tgt_x = {{(CW-8){1'b0}}, sync_tgt_reg};
    assign ver_tgt_x  = {{(CW-8){1'b0}}, verify_tgt_reg};
    assign sync_cnt_x = {{(CW-COUNT_BITS){1'b0}}, sync_cnt_reg};
    assign ver_cnt_x  = {{(CW-COUNT_BITS){1'b0}}, ver_cnt_reg};
    assign idx_x      = {{(CW-8){1'b0}}, sample_index};
    assign rs_x       = {{(CW-8){1'b0}}, report_sync_count};
    assign rv_x       = {{(CW-8){1'b0}}, report_verify_count};

    assign sess_match = ({1'b0, session_id} == sess_reg);

    // request checks
    assign cur_x = (req_phase == PH_SYNC) ? sync_cnt_x : ver_cnt_x;
    assign tgt_x = (req_phase == PH_SYNC) ? sync_tgt_x : ver_tgt_x;
    assign retry = (cur_x != '0) && (idx_x == cur_x - CW'(1));
    assign entering = (phase_reg == PH_SYNC) && (sync_cnt_x == sync_tgt_x)
                      && (idx_x == '0);
    assign continuing = (phase_reg == PH_VERIFY) && (cur_x <= ver_tgt_x)
                        && ((idx_x == cur_x) || retry);

    always_comb begin
        req_ok = 1'b0;
        unique case (req_phase)
            PH_SYNC: begin
                req_ok = (phase_reg == PH_SYNC) && (cur_x <= sync_tgt_x)
                         && ((idx_x == cur_x) || retry);
            end
            PH_VERIFY: begin
                req_ok = entering || continuing;
            end
            default: begin
                req_ok = 1'b0;
            end
        endcase
        // a full phase takes only a repeat of its last sample
        if ((cur_x >= tgt_x) && !retry) begin
            req_ok = 1'b0;
        end
    end

    assign rpt_ok = (phase_reg == PH_VERIFY) && (sync_cnt_x == sync_tgt_x)
                    && (ver_cnt_x == ver_tgt_x) && (rs_x == sync_tgt_x)
                    && (rv_x == ver_tgt_x);

    always_comb begin
        active_next   = active_reg;
        phase_next    = phase_reg;
        sess_next     = sess_reg;
        sync_cnt_next = sync_cnt_reg;
        ver_cnt_next  = ver_cnt_reg;
        offset_next   = offset_reg;
        rtt_next      = rtt_reg;
        source_next   = source_reg;
        res_ctl.kind   = K_NONE;
        res_ctl.status = 1'b0;
        res_ctl.echo   = 1'b0;
        unique case (func)
            FN_START: begin
                active_next    = 1'b1;
                phase_next     = PH_SYNC;
                sess_next      = {1'b0, session_id};
                sync_cnt_next  = '0;
                ver_cnt_next   = '0;
                offset_next    = '0;
                rtt_next       = '0;
                source_next    = '0;
                res_ctl.kind   = K_STARTED;
                res_ctl.status = 1'b1;
            end
            FN_REQUEST: begin
                if (!active_reg) begin
                    res_ctl.kind = K_NOT_STARTED;
                end else if (!sess_match || !req_ok) begin
                    res_ctl.kind = K_MISMATCH;
                end else begin
                    phase_next = req_phase;
                    if (!retry) begin
                        if (req_phase == PH_SYNC) begin
                            sync_cnt_next = sync_cnt_reg + COUNT_BITS'(1);
                        end else begin
                            ver_cnt_next = ver_cnt_reg + COUNT_BITS'(1);
                        end
                    end
                    res_ctl.kind   = K_REPLY;
                    res_ctl.status = 1'b1;
                    res_ctl.echo   = 1'b1;
                end
            end
            FN_REPORT: begin
                if (!active_reg) begin
                    res_ctl.kind = K_NOT_STARTED;
                end else if (!sess_match || !rpt_ok) begin
                    res_ctl.kind = K_MISMATCH;
                end else begin
                    phase_next     = PH_COMPLETE;
                    offset_next    = offset_ns;
                    rtt_next       = rtt_ns;
                    source_next    = offset_source;
                    sync_cnt_next  = COUNT_BITS'(report_sync_count);
                    ver_cnt_next   = COUNT_BITS'(report_verify_count);
                    res_ctl.kind   = K_ACCEPTED;
                    res_ctl.status = 1'b1;
                end
            end
            FN_CANCEL: begin
                if (active_reg) begin
                    // session number stays for the status report
                    active_next    = 1'b0;
                    phase_next     = PH_IDLE;
                    res_ctl.kind   = K_CANCELLED;
                    res_ctl.status = 1'b1;
                end
            end
            FN_RESET: begin
                active_next   = 1'b0;
                phase_next    = PH_IDLE;
                sess_next     = '1;
                sync_cnt_next = '0;
                ver_cnt_next  = '0;
                offset_next   = '0;
                rtt_next      = '0;
                source_next   = '0;
            end
            default: begin
            end
        endcase
        // reported phase is the state after the item, idle for error kinds
        res_ctl.phase = res_ctl.status ? phase_next : PH_IDLE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            phase_reg    <= PH_IDLE;
            sess_reg     <= '1;
            sync_cnt_reg <= '0;
            ver_cnt_reg  <= '0;
            offset_reg   <= '0;
            rtt_reg      <= '0;
            source_reg   <= '0;
        end else if (step) begin
            active_reg   <= active_next;
            phase_reg    <= phase_next;
            sess_reg     <= sess_next;
            sync_cnt_reg <= sync_cnt_next;
            ver_cnt_reg  <= ver_cnt_next;
            offset_reg   <= offset_next;
            rtt_reg      <= rtt_next;
            source_reg   <= source_next;
        end
    end

    // status fields show the state after the item, zero for error kinds
    assign session_out        = res_ctl.status ? sess_next : '0;
    assign sync_count_out     = res_ctl.status ? sync_cnt_next : '0;
    assign verify_count_out   = res_ctl.status ? ver_cnt_next : '0;
    assign adopted_offset_out = res_ctl.status ? offset_next : '0;
    assign adopted_rtt_out    = res_ctl.status ? rtt_next : '0;
    assign adopted_source_out = res_ctl.status ? source_next : '0;

endmodule

FILE: rtl/time_sync_session_sequencer_top.sv
// time_sync_session_sequencer_top: input register, sequencer and result register.
// Depends on tss_pkg and tss_sequencer.
//
//  channel | ports          | handshake        | moves
//  --------+----------------+------------------+------------------------------
//  input   | s_*            | s_valid/s_ready  | one event item
//  result  | m_*            | m_valid/m_ready  | one result item per event
//  config  | cfg_*          | cfg_wr_en        | target write, no wait
//
// One item per cycle sustained while results are taken; an item passes the input
// register, then the result register, with the single decision pass in tss_sequencer between them.
// Sync reset (aresetn low) empties both registers, closes any session and loads
// targets 8 and 4. A stalled result holds the result register; the input register
// then holds one more item and s_ready drops until the result is taken.
module time_sync_session_sequencer_top
    import tss_pkg::*;
#(
    parameter int SESSION_BITS = 16,
    parameter int COUNT_BITS   = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [7:0]                    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_func,
    input  logic [SESSION_BITS-1:0]       s_session_id,
    input  logic [1:0]                    s_req_phase,
    input  logic [7:0]                    s_sample_index,
    input  logic signed [63:0]            s_t1_ns,
    input  logic signed [63:0]            s_rx_time_ns,
    input  logic signed [63:0]            s_tx_time_ns,
    input  logic [7:0]                    s_report_sync_count,
    input  logic [7:0]                    s_report_verify_count,
    input  logic signed [63:0]            s_offset_ns,
    input  logic signed [63:0]            s_rtt_ns,
    input  logic [1:0]                    s_offset_source,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_result_kind,
    output logic [1:0]                    m_phase_out,
    output logic signed [SESSION_BITS:0]  m_session_out,
    output logic [COUNT_BITS-1:0]         m_sync_count_out,
    output logic [COUNT_BITS-1:0]         m_verify_count_out,
    output logic [7:0]                    m_last_index_out,
    output logic signed [63:0]            m_t1_out,
    output logic signed [63:0]            m_t2_out,
    output logic signed [63:0]            m_t3_out,
    output logic signed [63:0]            m_adopted_offset_out,
    output logic signed [63:0]            m_adopted_rtt_out,
    output logic [1:0]                    m_adopted_source_out
);

    logic                      in_vld_reg;
    func_t                     func_reg;
    logic [SESSION_BITS-1:0]   sid_reg;
    phase_t                    rphase_reg;
    logic [7:0]                idx_reg;
    logic signed [63:0]        t1_reg, t2_reg, t3_reg;
    logic [7:0]                rs_reg, rv_reg;
    logic signed [63:0]        offset_in_reg, rtt_in_reg;
    logic [1:0]                source_in_reg;
    logic                      in_adv;

    tss_res_ctl_t                 res_ctl;
    logic signed [SESSION_BITS:0] res_sess;
    logic [COUNT_BITS-1:0]        res_sync, res_ver;
    logic signed [63:0]           res_offset, res_rtt;
    logic [1:0]                   res_source;

    logic                         out_vld_reg;
    kind_t                        kind_reg;
    phase_t                       phase_reg;
    logic signed [SESSION_BITS:0] sess_reg;
    logic [COUNT_BITS-1:0]        sync_reg, ver_reg;
    logic [7:0]                   last_idx_reg;
    logic signed [63:0]           t1_out_reg, t2_out_reg, t3_out_reg;
    logic signed [63:0]           offset_reg, rtt_reg;
    logic [1:0]                   source_reg;

    assign in_adv  = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || in_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg      <= s_func;
            sid_reg       <= s_session_id;
            rphase_reg    <= s_req_phase;
            idx_reg       <= s_sample_index;
            t1_reg        <= s_t1_ns;
            t2_reg        <= s_rx_time_ns;
            t3_reg        <= s_tx_time_ns;
            rs_reg        <= s_report_sync_count;
            rv_reg        <= s_report_verify_count;
            offset_in_reg <= s_offset_ns;
            rtt_in_reg    <= s_rtt_ns;
            source_in_reg <= s_offset_source;
        end
    end

    tss_sequencer #(
        .SESSION_BITS (SESSION_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_seq (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .step                (in_adv),
        .func                (func_reg),
        .session_id          (sid_reg),
        .req_phase           (rphase_reg),
        .sample_index        (idx_reg),
        .report_sync_count   (rs_reg),
        .report_verify_count (rv_reg),
        .offset_ns           (offset_in_reg),
        .rtt_ns              (rtt_in_reg),
        .offset_source       (source_in_reg),
        .res_ctl             (res_ctl),
        .session_out         (res_sess),
        .sync_count_out      (res_sync),
        .verify_count_out    (res_ver),
        .adopted_offset_out  (res_offset),
        .adopted_rtt_out     (res_rtt),
        .adopted_source_out  (res_source)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (in_adv) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv) begin
            kind_reg     <= res_ctl.kind;
            phase_reg    <= res_ctl.phase;
            sess_reg     <= res_sess;
            sync_reg     <= res_sync;
            ver_reg      <= res_ver;
            last_idx_reg <= res_ctl.echo ? idx_reg : '0;
            t1_out_reg   <= res_ctl.echo ? t1_reg : '0;
            t2_out_reg   <= res_ctl.echo ? t2_reg : '0;
            t3_out_reg   <= res_ctl.echo ? t3_reg : '0;
            offset_reg   <= res_offset;
            rtt_reg      <= res_rtt;
            source_reg   <= res_source;
        end
    end

    assign m_valid              = out_vld_reg;
    assign m_result_kind        = kind_reg;
    assign m_phase_out          = phase_reg;
    assign m_session_out        = sess_reg;
    assign m_sync_count_out     = sync_reg;
    assign m_verify_count_out   = ver_reg;
    assign m_last_index_out     = last_idx_reg;
    assign m_t1_out             = t1_out_reg;
    assign m_t2_out             = t2_out_reg;
    assign m_t3_out             = t3_out_reg;
    assign m_adopted_offset_out = offset_reg;
    assign m_adopted_rtt_out    = rtt_reg;
    assign m_adopted_source_out = source_reg;

    // an item leaving the input register always shows up as a result
    a_adv_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        in_adv |=> out_vld_reg)
        else $error("item advanced but no result registered");

    // input side only blocks when a held item faces a stalled result
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && out_vld_reg && !m_ready))
        else $error("input stalled without a stalled result");

    // error kinds carry zero status and echo
    a_zero_kinds: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && (kind_reg == K_NONE || kind_reg == K_NOT_STARTED
                         || kind_reg == K_MISMATCH))
        |-> (sess_reg == '0 && t1_out_reg == '0 && offset_reg == '0))
        else $error("error result carries nonzero fields");

    // a reply only leaves in sync or verify
    a_reply_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && kind_reg == K_REPLY)
        |-> (phase_reg == PH_SYNC || phase_reg == PH_VERIFY))
        else $error("reply outside sync or verify");

endmodule

FILE: tb/time_sync_session_sequencer_top_test.sv
// Self-checking bench for time_sync_session_sequencer_top: a directed table, then random
// session traffic under several target settings and handshake pressure patterns.
// Depends on tss_pkg and the RTL of the top level.
module time_sync_session_sequencer_top_test;
    import tss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 12;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 80;

    localparam func_t FN_SPARE_A = 3'd5;
    localparam func_t FN_SPARE_B = 3'd6;
    localparam func_t FN_SPARE_C = 3'd7;

    localparam logic [63:0] T_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] T_MAX = 64'h7fff_ffff_ffff_ffff;

    typedef struct packed {
        func_t       func;
        logic [15:0] session_id;
        phase_t      req_phase;
        logic [7:0]  sample_index;
        logic [63:0] t1;
        logic [63:0] rx_time;
        logic [63:0] tx_time;
        logic [7:0]  rep_sync;
        logic [7:0]  rep_verify;
        logic [63:0] offset;
        logic [63:0] rtt;
        logic [1:0]  source;
    } tss_event_t;

    typedef struct packed {
        kind_t       kind;
        phase_t      phase;
        logic [16:0] session;
        logic [7:0]  sync_cnt;
        logic [7:0]  verify_cnt;
        logic [7:0]  last_index;
        logic [63:0] t1;
        logic [63:0] t2;
        logic [63:0] t3;
        logic [63:0] offset;
        logic [63:0] rtt;
        logic [1:0]  source;
    } tss_result_t;

    typedef struct packed {
        tss_event_t  ev;
        logic        fixed;
        tss_result_t want;
    } tss_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_index = 1'b0;
    logic [7:0]         cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_func = '0;
    logic [15:0]        s_session_id = '0;
    logic [1:0]         s_req_phase = '0;
    logic [7:0]         s_sample_index = '0;
    logic signed [63:0] s_t1_ns = '0;
    logic signed [63:0] s_rx_time_ns = '0;
    logic signed [63:0] s_tx_time_ns = '0;
    logic [7:0]         s_report_sync_count = '0;
    logic [7:0]         s_report_verify_count = '0;
    logic signed [63:0] s_offset_ns = '0;
    logic signed [63:0] s_rtt_ns = '0;
    logic [1:0]         s_offset_source = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [2:0]         m_result_kind;
    logic [1:0]         m_phase_out;
    logic signed [16:0] m_session_out;
    logic [7:0]         m_sync_count_out;
    logic [7:0]         m_verify_count_out;
    logic [7:0]         m_last_index_out;
    logic signed [63:0] m_t1_out;
    logic signed [63:0] m_t2_out;
    logic signed [63:0] m_t3_out;
    logic signed [63:0] m_adopted_offset_out;
    logic signed [63:0] m_adopted_rtt_out;
    logic [1:0]         m_adopted_source_out;

    // sequencer shadow state
    logic        sq_active;
    phase_t      sq_phase;
    logic [16:0] sq_session;
    logic [7:0]  sq_sync_cnt;
    logic [7:0]  sq_verify_cnt;
    logic [63:0] sq_offset;
    logic [63:0] sq_rtt;
    logic [1:0]  sq_source;
    logic [7:0]  sync_target;
    logic [7:0]  verify_target;

    tss_result_t due_results[$];
    tss_row_t    stim_rows[$];
    int          fail_count = 0;
    int          sent_items = 0;
    int          cycle_count = 0;
    int          sender_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_request = 1'b0;
    int          hold_left = 0;
    logic [15:0] active_sid = '0;

    time_sync_session_sequencer_top dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_wr_en             (cfg_wr_en),
        .cfg_index             (cfg_index),
        .cfg_wdata             (cfg_wdata),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_func                (s_func),
        .s_session_id          (s_session_id),
        .s_req_phase           (s_req_phase),
        .s_sample_index        (s_sample_index),
        .s_t1_ns               (s_t1_ns),
        .s_rx_time_ns          (s_rx_time_ns),
        .s_tx_time_ns          (s_tx_time_ns),
        .s_report_sync_count   (s_report_sync_count),
        .s_report_verify_count (s_report_verify_count),
        .s_offset_ns           (s_offset_ns),
        .s_rtt_ns              (s_rtt_ns),
        .s_offset_source       (s_offset_source),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_result_kind         (m_result_kind),
        .m_phase_out           (m_phase_out),
        .m_session_out         (m_session_out),
        .m_sync_count_out      (m_sync_count_out),
        .m_verify_count_out    (m_verify_count_out),
        .m_last_index_out      (m_last_index_out),
        .m_t1_out              (m_t1_out),
        .m_t2_out              (m_t2_out),
        .m_t3_out              (m_t3_out),
        .m_adopted_offset_out  (m_adopted_offset_out),
        .m_adopted_rtt_out     (m_adopted_rtt_out),
        .m_adopted_source_out  (m_adopted_source_out)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic void clear_session_state();
        sq_active     = 1'b0;
        sq_phase      = PH_IDLE;
        sq_session    = '1;
        sq_sync_cnt   = '0;
        sq_verify_cnt = '0;
        sq_offset     = '0;
        sq_rtt        = '0;
        sq_source     = '0;
    endfunction

    function automatic tss_result_t status_of(input kind_t k);
        tss_result_t r;
        r            = '0;
        r.kind       = k;
        r.phase      = sq_phase;
        r.session    = sq_session;
        r.sync_cnt   = sq_sync_cnt;
        r.verify_cnt = sq_verify_cnt;
        r.offset     = sq_offset;
        r.rtt        = sq_rtt;
        r.source     = sq_source;
        return r;
    endfunction

    function automatic tss_result_t next_session_result(input tss_event_t ev);
        tss_result_t r;
        logic [7:0]  cur;
        logic [7:0]  tgt;
        logic [16:0] sid17;
        logic        retry;
        logic        ok;
        logic        entering;
        logic        continuing;
        r     = '0;
        sid17 = {1'b0, ev.session_id};
        case (ev.func)
            FN_START: begin
                clear_session_state();
                sq_active  = 1'b1;
                sq_phase   = PH_SYNC;
                sq_session = sid17;
                r = status_of(K_STARTED);
            end
            FN_REQUEST: begin
                if (!sq_active) begin
                    r.kind = K_NOT_STARTED;
                end else if (sid17 != sq_session) begin
                    r.kind = K_MISMATCH;
                end else begin
                    cur   = (ev.req_phase == PH_SYNC) ? sq_sync_cnt : sq_verify_cnt;
                    tgt   = (ev.req_phase == PH_SYNC) ? sync_target : verify_target;
                    // a repeat of the latest sample is answered again, not counted
                    retry = (cur != 8'd0) && (ev.sample_index == cur - 8'd1);
                    ok    = 1'b0;
                    if (ev.req_phase == PH_SYNC) begin
                        ok = (sq_phase == PH_SYNC) && (cur <= sync_target) &&
                             ((ev.sample_index == cur) || retry);
                    end else if (ev.req_phase == PH_VERIFY) begin
                        entering   = (sq_phase == PH_SYNC) && (sq_sync_cnt == sync_target) &&
                                     (ev.sample_index == 8'd0);
                        continuing = (sq_phase == PH_VERIFY) && (cur <= verify_target) &&
                                     ((ev.sample_index == cur) || retry);
                        ok = entering || continuing;
                    end
                    if (!ok || ((cur >= tgt) && !retry)) begin
                        r.kind = K_MISMATCH;
                    end else begin
                        sq_phase = ev.req_phase;
                        if (!retry) begin
                            if (ev.req_phase == PH_SYNC) sq_sync_cnt = sq_sync_cnt + 8'd1;
                            else sq_verify_cnt = sq_verify_cnt + 8'd1;
                        end
                        r = status_of(K_REPLY);
                        r.last_index = ev.sample_index;
                        r.t1 = ev.t1;
                        r.t2 = ev.rx_time;
                        r.t3 = ev.tx_time;
                    end
                end
            end
            FN_REPORT: begin
                if (!sq_active) begin
                    r.kind = K_NOT_STARTED;
                end else if (sid17 != sq_session) begin
                    r.kind = K_MISMATCH;
                end else if (sq_phase != PH_VERIFY || sq_sync_cnt != sync_target ||
                             sq_verify_cnt != verify_target || ev.rep_sync != sync_target ||
                             ev.rep_verify != verify_target) begin
                    r.kind = K_MISMATCH;
                end else begin
                    sq_phase      = PH_COMPLETE;
                    sq_offset     = ev.offset;
                    sq_rtt        = ev.rtt;
                    sq_source     = ev.source;
                    sq_sync_cnt   = ev.rep_sync;
                    sq_verify_cnt = ev.rep_verify;
                    r = status_of(K_ACCEPTED);
                end
            end
            FN_CANCEL: begin
                if (sq_active) begin
                    sq_phase = PH_IDLE;
                    r = status_of(K_CANCELLED);
                    sq_active = 1'b0;
                end
            end
            FN_RESET: clear_session_state();
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] wide_value();
        case ($urandom_range(7))
            0: return T_MIN;
            1: return T_MAX;
            2: return '0;
            3: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic tss_event_t ev_of(input func_t f, input logic [15:0] sid);
        tss_event_t e;
        e = '0;
        e.func = f;
        e.session_id = sid;
        return e;
    endfunction

    function automatic tss_event_t ev_req(input logic [15:0] sid, input phase_t ph,
                                          input logic [7:0] idx, input logic [63:0] t1,
                                          input logic [63:0] rx, input logic [63:0] tx);
        tss_event_t e;
        e = ev_of(FN_REQUEST, sid);
        e.req_phase    = ph;
        e.sample_index = idx;
        e.t1      = t1;
        e.rx_time = rx;
        e.tx_time = tx;
        return e;
    endfunction

    function automatic tss_event_t ev_report(input logic [15:0] sid, input logic [7:0] rs,
                                             input logic [7:0] rv, input logic [63:0] off,
                                             input logic [63:0] rtt, input logic [1:0] src);
        tss_event_t e;
        e = ev_of(FN_REPORT, sid);
        e.rep_sync   = rs;
        e.rep_verify = rv;
        e.offset = off;
        e.rtt    = rtt;
        e.source = src;
        return e;
    endfunction

    function automatic tss_event_t noise_event();
        tss_event_t e;
        e.func         = func_t'($urandom_range(7));
        e.session_id   = ($urandom_range(1) == 1) ? active_sid : 16'($urandom);
        e.req_phase    = phase_t'($urandom_range(3));
        e.sample_index = ($urandom_range(1) == 1) ? 8'($urandom_range(9)) : 8'($urandom);
        e.t1           = wide_value();
        e.rx_time      = wide_value();
        e.tx_time      = wide_value();
        e.rep_sync     = ($urandom_range(1) == 1) ? sync_target : 8'($urandom);
        e.rep_verify   = ($urandom_range(1) == 1) ? verify_target : 8'($urandom);
        e.offset       = wide_value();
        e.rtt          = wide_value();
        e.source       = 2'($urandom_range(3));
        return e;
    endfunction

    function automatic tss_row_t fixed_row(input tss_event_t ev, input tss_result_t want);
        tss_row_t row;
        row.ev = ev;
        row.fixed = 1'b1;
        row.want = want;
        return row;
    endfunction

    function automatic tss_row_t model_row(input tss_event_t ev);
        tss_row_t row;
        row.ev = ev;
        row.fixed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic tss_result_t only_kind(input kind_t k);
        tss_result_t r;
        r = '0;
        r.kind = k;
        return r;
    endfunction

    function automatic tss_result_t started_as(input logic [15:0] sid);
        tss_result_t r;
        r = '0;
        r.kind = K_STARTED;
        r.phase = PH_SYNC;
        r.session = {1'b0, sid};
        return r;
    endfunction

    // entered just after a falling edge, returns just after a falling edge
    task automatic push_event(input tss_event_t ev, input logic fixed, input tss_result_t want);
        tss_result_t predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_func                <= ev.func;
        s_session_id          <= ev.session_id;
        s_req_phase           <= ev.req_phase;
        s_sample_index        <= ev.sample_index;
        s_t1_ns               <= ev.t1;
        s_rx_time_ns          <= ev.rx_time;
        s_tx_time_ns          <= ev.tx_time;
        s_report_sync_count   <= ev.rep_sync;
        s_report_verify_count <= ev.rep_verify;
        s_offset_ns           <= ev.offset;
        s_rtt_ns              <= ev.rtt;
        s_offset_source       <= ev.source;
        s_valid               <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = next_session_result(ev);
        due_results.push_back(fixed ? want : predicted);
        if (ev.func <= FN_RESET) sent_items++;
        @(negedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // one session from start to report, with retries, stray items and early aborts
    task automatic run_session(input int st, input int vt);
        logic [15:0] sid;
        logic [7:0]  rs;
        logic [7:0]  rv;
        int          i;
        sid = 16'($urandom);
        active_sid = sid;
        push_event(ev_of(FN_START, sid), 1'b0, '0);
        for (i = 0; i < st; i++) begin
            push_event(ev_req(sid, PH_SYNC, i[7:0], wide_value(), wide_value(), wide_value()),
                       1'b0, '0);
            if ($urandom_range(9) == 0)
                push_event(ev_req(sid, PH_SYNC, i[7:0], wide_value(), wide_value(),
                                  wide_value()), 1'b0, '0);
            if ($urandom_range(49) == 0) push_event(noise_event(), 1'b0, '0);
            if ($urandom_range(99) == 0) begin
                push_event(ev_of(FN_CANCEL, sid), 1'b0, '0);
                return;
            end
        end
        for (i = 0; i < vt; i++) begin
            push_event(ev_req(sid, PH_VERIFY, i[7:0], wide_value(), wide_value(),
                              wide_value()), 1'b0, '0);
            if ($urandom_range(9) == 0)
                push_event(ev_req(sid, PH_VERIFY, i[7:0], wide_value(), wide_value(),
                                  wide_value()), 1'b0, '0);
            if ($urandom_range(49) == 0) push_event(noise_event(), 1'b0, '0);
            if ($urandom_range(99) == 0) begin
                push_event(ev_of(FN_RESET, sid), 1'b0, '0);
                return;
            end
        end
        rs = ($urandom_range(9) == 0) ? 8'(st + 1) : 8'(st);
        rv = ($urandom_range(9) == 0) ? 8'(vt - 1) : 8'(vt);
        push_event(ev_report(sid, rs, rv, wide_value(), wide_value(), 2'($urandom_range(3))),
                   1'b0, '0);
        case ($urandom_range(9))
            0: push_event(ev_of(FN_CANCEL, sid), 1'b0, '0);
            1: push_event(ev_of(FN_RESET, sid), 1'b0, '0);
            2: push_event(ev_report(sid, 8'(st), 8'(vt), wide_value(), wide_value(),
                                    2'($urandom_range(3))), 1'b0, '0);
            3: push_event(ev_req(sid, PH_VERIFY, 8'(vt), wide_value(), wide_value(),
                                 wide_value()), 1'b0, '0);
            default: ;
        endcase
    endtask

    task automatic run_phase(input int st, input int vt, input bit write_targets,
                             input int s_pct, input int r_pct, input int n_items,
                             input bit long_hold);
        int start_count;
        settle();
        if (write_targets) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_SYNC_TARGET;
            cfg_wdata <= st[7:0];
            @(negedge aclk);
            cfg_index <= CFG_VERIFY_TARGET;
            cfg_wdata <= vt[7:0];
            @(negedge aclk);
            cfg_wr_en <= 1'b0;
            sync_target = st[7:0];
            verify_target = vt[7:0];
        end
        sender_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        if (long_hold) hold_request = 1'b1;
        start_count = sent_items;
        while (sent_items - start_count < n_items) begin
            if ($urandom_range(99) < 75) run_session(st, vt);
            else push_event(noise_event(), 1'b0, '0);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        tss_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                $error("result_kind: expected no result, got %0h", m_result_kind);
                fail_count++;
            end else begin
                want = due_results.pop_front();
                check_field("result_kind", 64'(want.kind), 64'(m_result_kind));
                check_field("phase_out", 64'(want.phase), 64'(m_phase_out));
                check_field("session_out", 64'(want.session), 64'($unsigned(m_session_out)));
                check_field("sync_count_out", 64'(want.sync_cnt), 64'(m_sync_count_out));
                check_field("verify_count_out", 64'(want.verify_cnt),
                            64'(m_verify_count_out));
                check_field("last_index_out", 64'(want.last_index), 64'(m_last_index_out));
                check_field("t1_out", want.t1, m_t1_out);
                check_field("t2_out", want.t2, m_t2_out);
                check_field("t3_out", want.t3, m_t3_out);
                check_field("adopted_offset_out", want.offset, m_adopted_offset_out);
                check_field("adopted_rtt_out", want.rtt, m_adopted_rtt_out);
                check_field("adopted_source_out", 64'(want.source),
                            64'(m_adopted_source_out));
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int k;
        sync_target = SYNC_TARGET_RST;
        verify_target = VERIFY_TARGET_RST;
        clear_session_state();
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // reset targets 8 and 4 apply throughout this table
        stim_rows.push_back(fixed_row(ev_req(16'h0005, PH_SYNC, 8'd0, '0, '0, '0),
                                      only_kind(K_NOT_STARTED)));
        stim_rows.push_back(fixed_row(ev_report(16'h0005, 8'd8, 8'd4, T_MAX, T_MIN, 2'd1),
                                      only_kind(K_NOT_STARTED)));
        stim_rows.push_back(fixed_row(ev_of(FN_CANCEL, 16'h0000), only_kind(K_NONE)));
        stim_rows.push_back(fixed_row(ev_of(FN_SPARE_A, 16'hffff), only_kind(K_NONE)));
        stim_rows.push_back(fixed_row(ev_of(FN_SPARE_B, 16'hffff), only_kind(K_NONE)));
        stim_rows.push_back(fixed_row(ev_of(FN_SPARE_C, 16'hffff), only_kind(K_NONE)));
        stim_rows.push_back(fixed_row(ev_of(FN_START, 16'hffff), started_as(16'hffff)));
        stim_rows.push_back(fixed_row(ev_req(16'h0000, PH_SYNC, 8'd0, '0, '0, '0),
                                      only_kind(K_MISMATCH)));
        stim_rows.push_back(fixed_row(ev_req(16'hffff, PH_IDLE, 8'd0, '0, '0, '0),
                                      only_kind(K_MISMATCH)));
        stim_rows.push_back(fixed_row(ev_req(16'hffff, PH_COMPLETE, 8'd0, '0, '0, '0),
                                      only_kind(K_MISMATCH)));
        // verify before the sync samples are done
        stim_rows.push_back(fixed_row(ev_req(16'hffff, PH_VERIFY, 8'd0, '0, '0, '0),
                                      only_kind(K_MISMATCH)));
        stim_rows.push_back(fixed_row(ev_req(16'hffff, PH_SYNC, 8'hff, '0, '0, '0),
                                      only_kind(K_MISMATCH)));
        stim_rows.push_back(model_row(ev_req(16'hffff, PH_SYNC, 8'd0, T_MIN, T_MAX, '1)));
        stim_rows.push_back(model_row(ev_req(16'hffff, PH_SYNC, 8'd0, T_MAX, T_MIN, '0)));
        stim_rows.push_back(model_row(ev_req(16'hffff, PH_SYNC, 8'd1, '1, '0, T_MAX)));
        stim_rows.push_back(fixed_row(ev_report(16'hffff, 8'd8, 8'd4, '1, '1, 2'd3),
                                      only_kind(K_MISMATCH)));
        stim_rows.push_back(model_row(ev_of(FN_CANCEL, 16'hffff)));
        stim_rows.push_back(fixed_row(ev_req(16'hffff, PH_SYNC, 8'd2, '0, '0, '0),
                                      only_kind(K_NOT_STARTED)));
        stim_rows.push_back(fixed_row(ev_of(FN_START, 16'h0000), started_as(16'h0000)));
        stim_rows.push_back(fixed_row(ev_of(FN_RESET, 16'h0000), only_kind(K_NONE)));
        stim_rows.push_back(fixed_row(ev_of(FN_CANCEL, 16'h0000), only_kind(K_NONE)));
        for (k = 0; k < stim_rows.size(); k++)
            push_event(stim_rows[k].ev, stim_rows[k].fixed, stim_rows[k].want);

        run_phase(8, 4, 1'b0, 0, 0, 250, 1'b0);
        run_phase(1, 1, 1'b1, 61, 0, 200, 1'b0);
        run_phase(0, 3, 1'b1, 0, 61, 200, 1'b1);
        run_phase(255, 2, 1'b1, 22, 22, 350, 1'b0);
        run_phase(3, 0, 1'b1, 0, 0, 150, 1'b0);
        run_phase(2, 255, 1'b1, 22, 22, 350, 1'b0);
        run_phase(5, 6, 1'b1, 61, 61, 150, 1'b1);
        settle();

        if (fail_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule
